// File: design/hlre_pkg.sv
// Shared types, constants and the hex digit function for the hex line record encoder.
// Used by hlre_front, hlre_fifo, hlre_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package hlre_pkg;

    localparam int LINE_ADDR_W = 16;
    localparam int LINE_DATA_W = 64;
    localparam int Q_DEPTH     = 2;
    localparam int QPTR_W      = $clog2(Q_DEPTH);
    localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

    // input opcodes
    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_EXEC = 2'd1;

    // ASCII codes
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_X    = 8'h58;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_A    = 8'h41;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_EXEC,
        KIND_ERROR
    } t_kind;

    // one queued job for the back end
    typedef struct packed {
        t_kind                    kind;
        logic                     with_addr;
        logic [LINE_ADDR_W-1:0]   addr;
        logic [LINE_DATA_W-1:0]   data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_ADDR_S,
        BS_ADDR_HEX,
        BS_ADDR_NL,
        BS_X,
        BS_NIB,
        BS_SUM,
        BS_NL,
        BS_STAR,
        BS_ERR
    } t_bstate;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = CH_0 + {4'd0, nib};
        end else begin
            r = CH_A + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/hlre_front.sv
// Front end: accepts input beats, classifies them and tracks the next expected address.
// Depends on hlre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hlre_front #(
    parameter int ADDR_WIDTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_opcode,
    input  wire logic [hlre_pkg::LINE_ADDR_W-1:0]   i_line_address,
    input  wire logic [hlre_pkg::LINE_DATA_W-1:0]   i_line_bytes,
    input  wire hlre_pkg::t_q_stat                  i_q_stat,
    output logic                                    o_push,
    output hlre_pkg::t_cmd                          o_cmd
);
    import hlre_pkg::*;

    logic [ADDR_WIDTH-1:0] r_next_addr, n_next_addr;
    logic                  r_addr_known, n_addr_known;
    logic [ADDR_WIDTH-1:0] addr_ext;
    logic                  accept;
    logic                  aligned;

    // no beat is taken while reset is held
    assign o_in_ready = i_rst_n && !i_q_stat.full;
    assign accept     = i_in_valid && o_in_ready;
    assign addr_ext   = ADDR_WIDTH'(i_line_address);
    assign aligned    = (i_line_address[2:0] == 3'd0);

    always_comb begin
        o_push         = 1'b0;
        o_cmd.kind     = KIND_DATA;
        o_cmd.with_addr = !r_addr_known || (r_next_addr != addr_ext);
        o_cmd.addr     = i_line_address;
        o_cmd.data     = i_line_bytes;
        n_next_addr    = r_next_addr;
        n_addr_known   = r_addr_known;
        if (accept) begin
            if (i_opcode == OP_DATA) begin
                o_push = 1'b1;
                if (!aligned) begin
                    o_cmd.kind = KIND_ERROR;
                end else begin
                    n_next_addr  = addr_ext + ADDR_WIDTH'(8);
                    n_addr_known = 1'b1;
                end
            end else if (i_opcode == OP_EXEC) begin
                o_push     = 1'b1;
                o_cmd.kind = KIND_EXEC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_addr  <= '0;
            r_addr_known <= 1'b0;
        end else begin
            r_next_addr  <= n_next_addr;
            r_addr_known <= n_addr_known;
        end
    end

endmodule

`default_nettype wire

// File: design/hlre_fifo.sv
// Two-entry job queue between the front and back ends.
// Depends on hlre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hlre_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire hlre_pkg::t_cmd     i_cmd,
    input  wire logic               i_pop,
    output hlre_pkg::t_cmd          o_head,
    output hlre_pkg::t_q_stat       o_q_stat
);
    import hlre_pkg::*;

    t_cmd              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_q_stat.full  = (r_cnt == QCNT_W'(Q_DEPTH));
    assign o_q_stat.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_q_stat.full;
    assign do_pop         = i_pop && !o_q_stat.empty;
    assign o_head         = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/hlre_back.sv
// Back end: character sequencer with registered output, one character per beat.
// Depends on hlre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hlre_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire hlre_pkg::t_cmd         i_head,
    input  wire hlre_pkg::t_q_stat      i_q_stat,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [7:0]                  o_out_char,
    output logic                        o_last_char,
    output logic                        o_align_error
);
    import hlre_pkg::*;

    t_bstate                 r_state, n_state;
    logic [LINE_ADDR_W-1:0]  r_addr;
    logic [LINE_DATA_W-1:0]  r_data;
    logic [3:0]              r_sum;
    logic [3:0]              r_cnt;
    logic                    r_ovalid;
    logic [7:0]              r_ochar;
    logic                    r_olast;
    logic                    r_oerr;

    logic                    advance;
    logic                    take;
    logic [7:0]              cur_char;
    logic                    cur_last;
    logic                    cur_err;
    t_bstate                 first_state;

    assign advance = !r_ovalid || i_out_ready;

    // character produced by the current state
    always_comb begin
        cur_char = CH_NUL;
        cur_last = 1'b0;
        cur_err  = 1'b0;
        unique case (r_state)
            BS_IDLE:     cur_char = CH_NUL;
            BS_ADDR_S:   cur_char = CH_S;
            BS_ADDR_HEX: cur_char = hex_char(r_addr[LINE_ADDR_W-1 -: 4]);
            BS_ADDR_NL:  cur_char = CH_NL;
            BS_X:        cur_char = CH_X;
            BS_NIB:      cur_char = hex_char(r_data[LINE_DATA_W-1 -: 4]);
            BS_SUM:      cur_char = hex_char(r_sum);
            BS_NL: begin
                cur_char = CH_NL;
                cur_last = 1'b1;
            end
            BS_STAR:     cur_char = CH_STAR;
            BS_ERR: begin
                cur_char = CH_NUL;
                cur_last = 1'b1;
                cur_err  = 1'b1;
            end
            default:     cur_char = CH_NUL;
        endcase
        take  = advance && ((r_state == BS_IDLE) || cur_last);
        o_pop = take && !i_q_stat.empty;
    end

    always_comb begin
        unique case (i_head.kind)
            KIND_DATA:  first_state = i_head.with_addr ? BS_ADDR_S : BS_X;
            KIND_EXEC:  first_state = BS_STAR;
            KIND_ERROR: first_state = BS_ERR;
            default:    first_state = BS_ERR;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (take) begin
            n_state = i_q_stat.empty ? BS_IDLE : first_state;
        end else if (advance) begin
            unique case (r_state)
                BS_ADDR_S:   n_state = BS_ADDR_HEX;
                BS_ADDR_HEX: n_state = (r_cnt == 4'd3) ? BS_ADDR_NL : BS_ADDR_HEX;
                BS_ADDR_NL:  n_state = BS_X;
                BS_X:        n_state = BS_NIB;
                BS_NIB:      n_state = (r_cnt == 4'd15) ? BS_SUM : BS_NIB;
                BS_SUM:      n_state = BS_NL;
                BS_STAR:     n_state = BS_NL;
                default:     n_state = r_state;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (advance) begin
                r_ovalid <= (r_state != BS_IDLE);
            end
        end
    end

    // working registers and output payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_ochar <= cur_char;
            r_olast <= cur_last;
            r_oerr  <= cur_err;
        end
        if (o_pop) begin
            r_addr <= i_head.addr;
            r_data <= i_head.data;
            r_sum  <= '0;
            r_cnt  <= '0;
        end else if (advance) begin
            unique case (r_state)
                BS_ADDR_HEX: begin
                    r_addr <= {r_addr[LINE_ADDR_W-5:0], 4'd0};
                    r_cnt  <= r_cnt + 4'd1;
                end
                BS_NIB: begin
                    r_data <= {r_data[LINE_DATA_W-5:0], 4'd0};
                    r_sum  <= r_sum + r_data[LINE_DATA_W-1 -: 4];
                    r_cnt  <= r_cnt + 4'd1;
                end
                default: r_cnt <= '0;
            endcase
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_out_char    = r_ochar;
    assign o_last_char   = r_olast;
    assign o_align_error = r_oerr;

endmodule

`default_nettype wire

// File: design/hex_line_record_encoder_unit.sv
// Each item passes the job queue, then the sequencer state, then the output register.
// Throughput: one character per cycle while the receiver is ready; a data line is 19
// characters, or 25 with an address line, an execution start 2, a misaligned line 1,
// an ignored record none. The rate is set by the single character sequencer in hlre_back.
// Reset (synchronous, active low) empties the queue and clears the remembered address.
`timescale 1ns / 1ps
`default_nettype none

module hex_line_record_encoder_unit #(
    parameter int ADDR_WIDTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_opcode,
    input  wire logic [hlre_pkg::LINE_ADDR_W-1:0]   i_line_address,
    input  wire logic [hlre_pkg::LINE_DATA_W-1:0]   i_line_bytes,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [7:0]                              o_out_char,
    output logic                                    o_last_char,
    output logic                                    o_align_error
);
    import hlre_pkg::*;

    // Front end decides per item what must be printed (address line or not,
    // error, execution start) and keeps the next expected address, so that
    // decision is final at the accept beat. Ignored records never enter the queue.
    logic    push;
    logic    pop;
    t_cmd    cmd;
    t_cmd    head;
    t_q_stat q_stat;

    hlre_front #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_line_address (i_line_address),
        .i_line_bytes   (i_line_bytes),
        .i_q_stat       (q_stat),
        .o_push         (push),
        .o_cmd          (cmd)
    );

    // Two-deep job queue: the front keeps taking items while the back prints.
    hlre_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_q_stat (q_stat)
    );

    // Back end walks the character sequence; the next job is popped on the
    // beat that issues the final character of the current one, so there is
    // no gap between consecutive items.
    hlre_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_char    (o_out_char),
        .o_last_char   (o_last_char),
        .o_align_error (o_align_error)
    );

    // error beat is always a lone NUL that closes its item
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_align_error) |-> (o_last_char && (o_out_char == CH_NUL)))
        else $error("alignment error beat malformed");

    // ignored records must not reach the queue
    a_ignore_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_opcode[1]) |-> !push)
        else $error("ignored record pushed");

    // queue status is consistent
    a_q_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

    // a pop never happens on an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: bench/tb_hex_line_record_encoder_unit.sv
// Self-checking bench for hex_line_record_encoder_unit: random and directed lines in, characters out.
// Depends on hlre_pkg for opcodes and character codes; no files or arguments are read.
`timescale 1ns / 1ps

module tb_hex_line_record_encoder_unit;

    import hlre_pkg::*;

    // opcodes the package leaves unnamed
    localparam logic [1:0] OP_SKIP  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    // digit lookup, '0' in the top byte
    localparam logic [16*8-1:0] HEX_ASCII = "0123456789ABCDEF";

    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [1:0]             op;
        logic [LINE_ADDR_W-1:0] addr;
        logic [LINE_DATA_W-1:0] bytes;
    } t_line_item;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       err;
    } t_char_beat;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic [1:0]             i_opcode       = OP_SKIP;
    logic [LINE_ADDR_W-1:0] i_line_address = '0;
    logic [LINE_DATA_W-1:0] i_line_bytes   = '0;
    logic                   i_out_ready    = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [7:0]             o_out_char;
    logic                   o_last_char;
    logic                   o_align_error;

    hex_line_record_encoder_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_line_address (i_line_address),
        .i_line_bytes   (i_line_bytes),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_char     (o_out_char),
        .o_last_char    (o_last_char),
        .o_align_error  (o_align_error)
    );

    // lines waiting to be offered, and characters the encoder still owes us
    t_line_item pending_lines[$];
    t_char_beat expected_chars[$];

    // predictor state: mirrors the block's remembered next address
    logic [LINE_ADDR_W-1:0] pred_next_addr  = '0;
    logic                   pred_addr_known = 1'b0;

    // stimulus-side address tracker, used to build contiguous runs
    logic [LINE_ADDR_W-1:0] gen_next_addr = '0;

    // idling controls, changed only between phases
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // long receiver hold-off
    logic hold_trigger = 1'b0;
    int   hold_left    = 0;

    int mismatches      = 0;
    int lines_accepted  = 0;
    int chars_checked   = 0;
    int addr_lines_seen = 0;
    int misaligned_seen = 0;
    int exec_seen       = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // reset held from time zero and released once
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
        return HEX_ASCII[(15 - nib) * 8 +: 8];
    endfunction

    function automatic void owe_char(input logic [7:0] ch, input logic last,
                                     input logic err);
        t_char_beat b;
        b.ch   = ch;
        b.last = last;
        b.err  = err;
        expected_chars.push_back(b);
    endfunction

    // Works out the characters one accepted line should produce and updates
    // the predicted address state.
    function automatic void encode_line_chars(input logic [1:0] op,
                                              input logic [LINE_ADDR_W-1:0] addr,
                                              input logic [LINE_DATA_W-1:0] bytes);
        logic [3:0] csum;
        logic [3:0] nib;
        if (op == OP_EXEC) begin
            owe_char(CH_STAR, 1'b0, 1'b0);
            owe_char(CH_NL, 1'b1, 1'b0);
            exec_seen++;
        end else if (op == OP_DATA) begin
            if (addr[2:0] != 3'd0) begin
                // misaligned: single error beat, state untouched
                owe_char(CH_NUL, 1'b1, 1'b1);
                misaligned_seen++;
            end else begin
                // address line on first data line or on any jump
                if (!pred_addr_known || pred_next_addr != addr) begin
                    owe_char(CH_S, 1'b0, 1'b0);
                    for (int i = 3; i >= 0; i--) begin
                        owe_char(ascii_hex(addr[4*i +: 4]), 1'b0, 1'b0);
                    end
                    owe_char(CH_NL, 1'b0, 1'b0);
                    addr_lines_seen++;
                end
                owe_char(CH_X, 1'b0, 1'b0);
                csum = 4'd0;
                for (int i = 15; i >= 0; i--) begin
                    nib  = bytes[4*i +: 4];
                    csum = csum + nib;
                    owe_char(ascii_hex(nib), 1'b0, 1'b0);
                end
                owe_char(ascii_hex(csum), 1'b0, 1'b0);
                owe_char(CH_NL, 1'b1, 1'b0);
                pred_addr_known = 1'b1;
                pred_next_addr  = addr + 16'd8;
            end
        end
        // skip and spare opcodes: nothing owed
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Input driver: predicts on every accepted beat, then offers the next
    // queued line or idles. Valid only falls when no new line follows.
    always @(posedge i_clk) begin
        t_line_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                encode_line_chars(i_opcode, i_line_address, i_line_bytes);
                lines_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_lines.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_lines.pop_front();
                    i_in_valid     <= 1'b1;
                    i_opcode       <= nxt.op;
                    i_line_address <= nxt.addr;
                    i_line_bytes   <= nxt.bytes;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Hold-off counter for the long receiver stall.
    always @(posedge i_clk) begin
        if (hold_trigger) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Output monitor: checks each character beat against the oldest one owed,
    // then chooses whether to stall the next cycle.
    always @(posedge i_clk) begin
        t_char_beat want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                chars_checked++;
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("char 0x%02h with nothing owed", o_out_char));
                end else begin
                    want = expected_chars.pop_front();
                    if (o_out_char !== want.ch) begin
                        report_mismatch($sformatf("char 0x%02h, wanted 0x%02h",
                                                  o_out_char, want.ch));
                    end
                    if (o_last_char !== want.last) begin
                        report_mismatch($sformatf("last flag %b, wanted %b on char 0x%02h",
                                                  o_last_char, want.last, want.ch));
                    end
                    if (o_align_error !== want.err) begin
                        report_mismatch($sformatf("align error %b, wanted %b on char 0x%02h",
                                                  o_align_error, want.err, want.ch));
                    end
                end
            end
            i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_line(input logic [1:0] op, input logic [LINE_ADDR_W-1:0] addr,
                              input logic [LINE_DATA_W-1:0] bytes);
        t_line_item it;
        it.op    = op;
        it.addr  = addr;
        it.bytes = bytes;
        pending_lines.push_back(it);
    endtask

    // Mostly contiguous runs of data lines with random content; the rest is
    // jumps, wrap at the top of memory, execution starts, misaligned lines and
    // ignored records.
    task automatic queue_random_line();
        logic [1:0]             op;
        logic [LINE_ADDR_W-1:0] addr;
        logic [LINE_DATA_W-1:0] bytes;
        int                     pick;
        int                     how;
        pick  = $urandom_range(99);
        addr  = LINE_ADDR_W'($urandom);
        bytes = {$urandom, $urandom};
        if (pick < 70) begin
            op  = OP_DATA;
            how = $urandom_range(19);
            if (how < 14) begin
                addr = gen_next_addr;
            end else if (how < 18) begin
                addr[2:0] = 3'd0;
            end else begin
                addr = 16'hFFF8;
            end
            how = $urandom_range(15);
            if (how == 0) begin
                bytes = '0;
            end else if (how == 1) begin
                bytes = '1;
            end
            gen_next_addr = addr + 16'd8;
        end else if (pick < 80) begin
            op = OP_EXEC;
        end else if (pick < 90) begin
            op        = OP_DATA;
            addr[2:0] = 3'($urandom_range(7, 1));
        end else begin
            op = ($urandom_range(1) != 0) ? OP_SKIP : OP_SPARE;
        end
        queue_line(op, addr, bytes);
    endtask

    // Sender pause: nothing offered until every owed character has come.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_lines.size() != 0 || i_in_valid || expected_chars.size() != 0);
    endtask

    task automatic run_random_phase(input int n, input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int k = 0; k < n; k++) begin
            queue_random_line();
        end
        wait_drained();
    endtask

    initial begin
        @(posedge i_rst_n);
        @(negedge i_clk);

        // Directed: ignored records first, so the first data line at address
        // zero must still carry an address line.
        queue_line(OP_SKIP,  16'h0000, 64'h0);
        queue_line(OP_SPARE, 16'h1234, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_line(OP_DATA,  16'h0000, 64'h0);
        queue_line(OP_DATA,  16'h0008, 64'hFFFF_FFFF_FFFF_FFFF);  // contiguous, checksum wraps
        queue_line(OP_DATA,  16'h0011, 64'h0123_4567_89AB_CDEF);  // misaligned
        queue_line(OP_DATA,  16'h0010, 64'hFEDC_BA98_7654_3210);  // still contiguous
        queue_line(OP_EXEC,  16'h0000, 64'h0);
        queue_line(OP_DATA,  16'hFFF8, 64'h0123_4567_89AB_CDEF);
        queue_line(OP_DATA,  16'h0000, 64'h8000_0000_0000_0001);  // wraps to zero, no jump
        queue_line(OP_DATA,  16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);  // misaligned at the top
        queue_line(OP_DATA,  16'h5AA0, 64'hA5A5_A5A5_A5A5_A5A5);
        queue_line(OP_SKIP,  16'h5AA9, 64'h5A5A_5A5A_5A5A_5A5A);  // ignored even if misaligned
        queue_line(OP_SPARE, 16'h0003, 64'h0);
        queue_line(OP_DATA,  16'h5AA8, 64'h5A5A_5A5A_5A5A_5A5A);
        queue_line(OP_EXEC,  16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_line(OP_DATA,  16'h0008, 64'h1111_1111_1111_1111);
        queue_line(OP_DATA,  16'h0007, 64'h0);
        queue_line(OP_DATA,  16'hA550, 64'h0F0F_0F0F_F0F0_F0F0);
        gen_next_addr = 16'hA558;
        wait_drained();

        run_random_phase(90, 0, 0);
        run_random_phase(90, 52, 0);
        run_random_phase(90, 0, 52);
        run_random_phase(90, 11, 11);

        // Back-pressure: receiver holds off while lines keep coming, so the
        // internal queue fills and the input stalls.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_trigger   = 1'b1;
        @(negedge i_clk);
        hold_trigger   = 1'b0;
        for (int k = 0; k < 30; k++) begin
            queue_random_line();
        end
        wait_drained();

        // let any stray beats show up
        repeat (30) @(negedge i_clk);

        $display("Ran %0d lines: %0d characters checked, %0d address lines, %0d misaligned,",
                 lines_accepted, chars_checked, addr_lines_seen, misaligned_seen);
        $display("%0d execution starts, under no, sender, receiver, mixed and long stalls.",
                 exec_seen);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/hlre_pkg.sv
design/hlre_front.sv
design/hlre_fifo.sv
design/hlre_back.sv
design/hex_line_record_encoder_unit.sv
bench/tb_hex_line_record_encoder_unit.sv
